FILE: src/dhf_pkg.sv
// shared types, constants and helper functions for the depth hole filler
package dhf_pkg;

    localparam int MAX_WIDTH_DEF = 512;
    localparam int PIX_W         = 8;
    localparam int FW_W          = 10;
    localparam int FH_W          = 13;
    localparam int ROW_W         = 12;
    localparam int SUM_W         = 11;
    localparam int CNT_W         = 4;
    localparam int RECIP_W       = 17;
    localparam int RECIP_SH      = 16;
    localparam int PROD_W        = SUM_W + RECIP_W;
    localparam int NBR_W         = 3;
    localparam int PADDR_W       = 3;
    localparam int PDATA_W       = 32;

    localparam logic [FW_W-1:0] FW_RESET   = FW_W'(512);
    localparam logic [FH_W-1:0] FH_RESET   = FH_W'(424);
    localparam logic [FH_W-1:0] HEIGHT_MAX = FH_W'(4096);

    localparam logic CMD_PIXEL = 1'b0;
    localparam logic CMD_DRAIN = 1'b1;

    localparam logic REG_FRAME_WIDTH  = 1'b0;
    localparam logic REG_FRAME_HEIGHT = 1'b1;

    // neighbor visiting order, raster order around the center
    localparam logic [NBR_W-1:0] NBR_UL = 3'd0;
    localparam logic [NBR_W-1:0] NBR_U  = 3'd1;
    localparam logic [NBR_W-1:0] NBR_UR = 3'd2;
    localparam logic [NBR_W-1:0] NBR_L  = 3'd3;
    localparam logic [NBR_W-1:0] NBR_R  = 3'd4;
    localparam logic [NBR_W-1:0] NBR_DL = 3'd5;
    localparam logic [NBR_W-1:0] NBR_D  = 3'd6;
    localparam logic [NBR_W-1:0] NBR_DR = 3'd7;

    typedef struct packed {
        logic             latch;
        logic             use_live;
        logic             wr_input;
        logic             wr_live;
        logic             rd_center;
        logic             rd_nbr;
        logic [NBR_W-1:0] nbr_idx;
        logic             clr_acc;
        logic             acc_en;
        logic             div_en;
        logic             quo_en;
        logic             take_center;
        logic             emit;
    } t_dp_cmd;

    typedef struct packed {
        logic emit_live;
        logic write_only;
        logic drain;
        logic center_zero;
        logic out_free;
        logic use_live;
    } t_dp_stat;

    // ceil(2^16 / cnt), exact floor division for sums below 2^11
    function automatic logic [RECIP_W-1:0] dhf_recip(input logic [CNT_W-1:0] cnt);
        logic [RECIP_W-1:0] r;
        case (cnt)
            4'd1:    r = 17'd65536;
            4'd2:    r = 17'd32768;
            4'd3:    r = 17'd21846;
            4'd4:    r = 17'd16384;
            4'd5:    r = 17'd13108;
            4'd6:    r = 17'd10923;
            4'd7:    r = 17'd9363;
            4'd8:    r = 17'd8192;
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

FILE: src/dhf_if.sv
// valid/ready channel interfaces for pixel input and filled output
interface dhf_in_if;
    logic                     valid;
    logic                     ready;
    logic                     cmd;
    logic [dhf_pkg::PIX_W-1:0] pixel_value;

    modport source (output valid, output cmd, output pixel_value, input ready);
    modport sink   (input valid, input cmd, input pixel_value, output ready);
endinterface

interface dhf_out_if;
    logic                     valid;
    logic                     ready;
    logic [dhf_pkg::PIX_W-1:0] filled_value;
    logic                     frame_end;

    modport source (output valid, output filled_value, output frame_end, input ready);
    modport sink   (input valid, input filled_value, input frame_end, output ready);
endinterface

FILE: src/depth_hole_fill_neighbor_mean_top.sv
// top level: configuration registers, channel hookup, controller and datapath
//
// Streaming 3x3 hole filler for 8-bit depth frames. Pixels enter in raster
// order; a zero pixel is replaced by the floor of the mean of its nonzero
// in-frame neighbors (above and left already filled, right and below raw),
// and results leave in raster order one line plus one pixel behind the input.
// After the last pixel of a frame, each further transaction, drain or pixel,
// flushes one pending pixel, the last one flagged with frame_end. Frame
// width and height sit at byte addresses 0 and 4 of the APB port; any write
// restarts the frame. The block works on one transaction at a time. A nonzero
// pixel is read as the center and emitted; a hole also visits the eight
// neighbors one per cycle through the single read port of the pixel ring,
// then a registered reciprocal multiply. The emit waits while the output
// register is full; the incoming pixel is then stored behind the emitted one.
module depth_hole_fill_neighbor_mean_top #(
    parameter int MAX_WIDTH = dhf_pkg::MAX_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    dhf_in_if.sink                        i_pix,
    dhf_out_if.source                     o_res,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [dhf_pkg::PADDR_W-1:0]   paddr,
    input  logic [dhf_pkg::PDATA_W-1:0]   pwdata,
    output logic [dhf_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready
);
    import dhf_pkg::*;

    localparam int WW = $clog2(MAX_WIDTH + 1);

    logic [FW_W-1:0] r_frame_width;
    logic [FH_W-1:0] r_frame_height;
    logic            cfg_wr;
    logic [WW-1:0]   eff_width;
    logic [FH_W-1:0] eff_height;
    t_dp_cmd         dp_cmd;
    t_dp_stat        dp_stat;
    logic            in_ready;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= FW_RESET;
            r_frame_height <= FH_RESET;
        end else if (cfg_wr) begin
            unique case (paddr[2])
                REG_FRAME_WIDTH:  r_frame_width  <= pwdata[FW_W-1:0];
                REG_FRAME_HEIGHT: r_frame_height <= pwdata[FH_W-1:0];
                default:          r_frame_width  <= r_frame_width;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_FRAME_WIDTH:  prdata = PDATA_W'(r_frame_width);
            REG_FRAME_HEIGHT: prdata = PDATA_W'(r_frame_height);
            default:          prdata = '0;
        endcase
    end

    // clamp the frame size to what the ring supports
    always_comb begin
        if (r_frame_width == '0) begin
            eff_width = WW'(1);
        end else if (int'(r_frame_width) > MAX_WIDTH) begin
            eff_width = WW'(MAX_WIDTH);
        end else begin
            eff_width = WW'(r_frame_width);
        end
        if (r_frame_height == '0) begin
            eff_height = FH_W'(1);
        end else if (r_frame_height > HEIGHT_MAX) begin
            eff_height = HEIGHT_MAX;
        end else begin
            eff_height = r_frame_height;
        end
    end

    dhf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_pix.valid),
        .o_in_ready (in_ready),
        .i_stat     (dp_stat),
        .o_cmd      (dp_cmd)
    );

    dhf_datapath #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_eff_width    (eff_width),
        .i_eff_height   (eff_height),
        .i_cfg_clear    (cfg_wr),
        .i_in_cmd       (i_pix.cmd),
        .i_in_pixel     (i_pix.pixel_value),
        .i_out_ready    (o_res.ready),
        .i_cmd          (dp_cmd),
        .o_stat         (dp_stat),
        .o_out_valid    (o_res.valid),
        .o_filled_value (o_res.filled_value),
        .o_frame_end    (o_res.frame_end)
    );

    assign i_pix.ready = in_ready;

endmodule

FILE: src/dhf_ctrl.sv
// sequencing state machine for the hole filler datapath
module dhf_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  dhf_pkg::t_dp_stat i_stat,
    output dhf_pkg::t_dp_cmd  o_cmd
);
    import dhf_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CENTER,
        S_NBR,
        S_DIV,
        S_QUO,
        S_OUT,
        S_WIN
    } t_state;

    t_state           r_state;
    logic [NBR_W-1:0] r_k;

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    if (i_stat.emit_live) begin
                        o_cmd.latch     = 1'b1;
                        o_cmd.use_live  = 1'b1;
                        o_cmd.rd_center = 1'b1;
                    end else if (i_stat.write_only) begin
                        o_cmd.wr_input = 1'b1;
                    end else if (i_stat.drain) begin
                        o_cmd.latch     = 1'b1;
                        o_cmd.rd_center = 1'b1;
                    end
                end
            end
            S_CENTER: begin
                if (i_stat.center_zero) begin
                    o_cmd.clr_acc = 1'b1;
                    o_cmd.rd_nbr  = 1'b1;
                    o_cmd.nbr_idx = NBR_UL;
                end else begin
                    o_cmd.take_center = 1'b1;
                end
            end
            S_NBR: begin
                o_cmd.acc_en = 1'b1;
                if (r_k != NBR_DR) begin
                    o_cmd.rd_nbr  = 1'b1;
                    o_cmd.nbr_idx = r_k + NBR_W'(1);
                end
            end
            S_DIV: o_cmd.div_en = 1'b1;
            S_QUO: o_cmd.quo_en = 1'b1;
            S_OUT: o_cmd.emit   = i_stat.out_free;
            S_WIN: o_cmd.wr_live = 1'b1;
            default: o_cmd = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_k     <= NBR_UL;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid && (i_stat.emit_live || i_stat.drain)) begin
                        r_state <= S_CENTER;
                    end
                end
                S_CENTER: begin
                    if (i_stat.center_zero) begin
                        r_k     <= NBR_UL;
                        r_state <= S_NBR;
                    end else begin
                        r_state <= S_OUT;
                    end
                end
                S_NBR: begin
                    if (r_k == NBR_DR) begin
                        r_state <= S_DIV;
                    end else begin
                        r_k <= r_k + NBR_W'(1);
                    end
                end
                S_DIV: r_state <= S_QUO;
                S_QUO: r_state <= S_OUT;
                S_OUT: begin
                    if (i_stat.out_free) begin
                        r_state <= i_stat.use_live ? S_WIN : S_IDLE;
                    end
                end
                S_WIN: r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

FILE: src/dhf_datapath.sv
// pixel ring, raster counters, neighbor accumulator, divider and output register
module dhf_datapath #(
    parameter int MAX_WIDTH = dhf_pkg::MAX_WIDTH_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic [$clog2(MAX_WIDTH+1)-1:0]   i_eff_width,
    input  logic [dhf_pkg::FH_W-1:0]         i_eff_height,
    input  logic                             i_cfg_clear,
    input  logic                             i_in_cmd,
    input  logic [dhf_pkg::PIX_W-1:0]        i_in_pixel,
    input  logic                             i_out_ready,
    input  dhf_pkg::t_dp_cmd                 i_cmd,
    output dhf_pkg::t_dp_stat                o_stat,
    output logic                             o_out_valid,
    output logic [dhf_pkg::PIX_W-1:0]        o_filled_value,
    output logic                             o_frame_end
);
    import dhf_pkg::*;

    localparam int WW   = $clog2(MAX_WIDTH + 1);
    localparam int CW   = $clog2(MAX_WIDTH);
    localparam int PW   = $clog2(MAX_WIDTH + 2);
    localparam int RING = 2 * MAX_WIDTH + 2;
    localparam int AW   = $clog2(RING);
    localparam int AW1  = AW + 1;

    logic [PIX_W-1:0] r_mem [RING];

    logic [CW-1:0]    r_in_col;
    logic [ROW_W-1:0] r_in_row;
    logic             r_in_done;
    logic [CW-1:0]    r_out_col;
    logic [ROW_W-1:0] r_out_row;
    logic [PW-1:0]    r_pending;
    logic [AW-1:0]    r_in_addr;
    logic [AW-1:0]    r_out_addr;

    logic [PIX_W-1:0] r_live_pix;
    logic             r_use_live;
    logic [PIX_W-1:0] r_rdata;
    logic [NBR_W-1:0] r_rd_idx;
    logic [SUM_W-1:0] r_sum;
    logic [CNT_W-1:0] r_cnt;
    logic [PROD_W-1:0] r_prod;
    logic [PIX_W-1:0] r_res;

    logic             r_oval;
    logic [PIX_W-1:0] r_oval_pix;
    logic             r_ofe;

    logic [CW-1:0]    w_last;
    logic [ROW_W-1:0] h_last;
    logic [PW-1:0]    w_p1;
    logic             is_pixel;
    logic             frame_last;
    logic             nbr_neg;
    logic [AW1-1:0]   nbr_mag;
    logic [AW1-1:0]   off_mod;
    logic [AW1-1:0]   nsum;
    logic [AW-1:0]    nbr_addr;
    logic [AW-1:0]    rd_addr;
    logic [AW-1:0]    in_addr_inc;
    logic [AW-1:0]    out_addr_inc;
    logic             left_ok;
    logic             right_ok;
    logic             up_ok;
    logic             down_ok;
    logic             nbr_in;
    logic [PIX_W-1:0] nbr_val;
    logic             wr_en;
    logic [AW-1:0]    wr_addr;
    logic [PIX_W-1:0] wr_data;

    assign w_last     = CW'(i_eff_width - WW'(1));
    assign h_last     = ROW_W'(i_eff_height - FH_W'(1));
    assign w_p1       = PW'(i_eff_width) + PW'(1);
    assign is_pixel   = (i_in_cmd == CMD_PIXEL);
    assign frame_last = (r_out_col == w_last) && (r_out_row == h_last);

    assign in_addr_inc  = (r_in_addr == AW'(RING - 1)) ? '0 : r_in_addr + AW'(1);
    assign out_addr_inc = (r_out_addr == AW'(RING - 1)) ? '0 : r_out_addr + AW'(1);

    // ring address of a neighbor relative to the output position
    always_comb begin
        nbr_neg = 1'b1;
        nbr_mag = AW1'(1);
        case (i_cmd.nbr_idx)
            NBR_UL: nbr_mag = AW1'(i_eff_width) + AW1'(1);
            NBR_U:  nbr_mag = AW1'(i_eff_width);
            NBR_UR: nbr_mag = AW1'(i_eff_width) - AW1'(1);
            NBR_L:  nbr_mag = AW1'(1);
            NBR_R: begin
                nbr_neg = 1'b0;
                nbr_mag = AW1'(1);
            end
            NBR_DL: begin
                nbr_neg = 1'b0;
                nbr_mag = AW1'(i_eff_width) - AW1'(1);
            end
            NBR_D: begin
                nbr_neg = 1'b0;
                nbr_mag = AW1'(i_eff_width);
            end
            NBR_DR: begin
                nbr_neg = 1'b0;
                nbr_mag = AW1'(i_eff_width) + AW1'(1);
            end
            default: nbr_mag = AW1'(1);
        endcase
    end

    assign off_mod  = nbr_neg ? AW1'(RING) - nbr_mag : nbr_mag;
    assign nsum     = {1'b0, r_out_addr} + off_mod;
    assign nbr_addr = (nsum >= AW1'(RING)) ? AW'(nsum - AW1'(RING)) : AW'(nsum);
    assign rd_addr  = i_cmd.rd_center ? r_out_addr : nbr_addr;

    // neighbor inside the frame
    assign left_ok  = (r_out_col != '0);
    assign right_ok = (r_out_col != w_last);
    assign up_ok    = (r_out_row != '0);
    assign down_ok  = (r_out_row != h_last);

    always_comb begin
        case (r_rd_idx)
            NBR_UL:  nbr_in = up_ok && left_ok;
            NBR_U:   nbr_in = up_ok;
            NBR_UR:  nbr_in = up_ok && right_ok;
            NBR_L:   nbr_in = left_ok;
            NBR_R:   nbr_in = right_ok;
            NBR_DL:  nbr_in = down_ok && left_ok;
            NBR_D:   nbr_in = down_ok;
            NBR_DR:  nbr_in = down_ok && right_ok;
            default: nbr_in = 1'b0;
        endcase
    end

    // with a live pixel, the down-right neighbor is the pixel just received, not yet in the ring
    assign nbr_val = (r_rd_idx == NBR_DR && r_use_live) ? r_live_pix : r_rdata;

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = r_in_addr;
        wr_data = i_in_pixel;
        if (i_cmd.wr_input) begin
            wr_en = 1'b1;
        end else if (i_cmd.wr_live) begin
            wr_en   = 1'b1;
            wr_data = r_live_pix;
        end else if (i_cmd.emit) begin
            wr_en   = 1'b1;
            wr_addr = r_out_addr;
            wr_data = r_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_center || i_cmd.rd_nbr) begin
            r_rdata <= r_mem[rd_addr];
        end
        if (i_cmd.rd_nbr) begin
            r_rd_idx <= i_cmd.nbr_idx;
        end
        if (i_cmd.latch) begin
            r_live_pix <= i_in_pixel;
            r_use_live <= i_cmd.use_live;
        end
        if (i_cmd.clr_acc) begin
            r_sum <= '0;
            r_cnt <= '0;
        end else if (i_cmd.acc_en && nbr_in && nbr_val != '0) begin
            r_sum <= r_sum + SUM_W'(nbr_val);
            r_cnt <= r_cnt + CNT_W'(1);
        end
        if (i_cmd.div_en) begin
            r_prod <= PROD_W'(r_sum) * PROD_W'(dhf_recip(r_cnt));
        end
        if (i_cmd.take_center) begin
            r_res <= r_rdata;
        end else if (i_cmd.quo_en) begin
            r_res <= r_prod[RECIP_SH +: PIX_W];
        end
    end

    // raster position counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cfg_clear || (i_cmd.emit && frame_last)) begin
            r_in_col   <= '0;
            r_in_row   <= '0;
            r_in_done  <= 1'b0;
            r_out_col  <= '0;
            r_out_row  <= '0;
            r_pending  <= '0;
            r_in_addr  <= '0;
            r_out_addr <= '0;
        end else if (i_cmd.wr_input || i_cmd.wr_live) begin
            r_pending <= r_pending + PW'(1);
            r_in_addr <= in_addr_inc;
            if (r_in_col == w_last) begin
                r_in_col <= '0;
                if (r_in_row == h_last) begin
                    r_in_done <= 1'b1;
                end else begin
                    r_in_row <= r_in_row + ROW_W'(1);
                end
            end else begin
                r_in_col <= r_in_col + CW'(1);
            end
        end else if (i_cmd.emit) begin
            r_pending  <= r_pending - PW'(1);
            r_out_addr <= out_addr_inc;
            if (r_out_col == w_last) begin
                r_out_col <= '0;
                r_out_row <= r_out_row + ROW_W'(1);
            end else begin
                r_out_col <= r_out_col + CW'(1);
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_oval <= 1'b0;
        end else if (i_cmd.emit) begin
            r_oval     <= 1'b1;
            r_oval_pix <= r_res;
            r_ofe      <= frame_last;
        end else if (i_out_ready) begin
            r_oval <= 1'b0;
        end
    end

    assign o_stat.emit_live   = is_pixel && !r_in_done && (r_pending == w_p1);
    assign o_stat.write_only  = is_pixel && !r_in_done && (r_pending != w_p1);
    assign o_stat.drain       = r_in_done && (r_pending != '0);
    assign o_stat.center_zero = (r_rdata == '0);
    assign o_stat.out_free    = !r_oval || i_out_ready;
    assign o_stat.use_live    = r_use_live;

    assign o_out_valid    = r_oval;
    assign o_filled_value = r_oval_pix;
    assign o_frame_end    = r_ofe;

endmodule

FILE: bench/dhf_fill_scoreboard.sv
// scoreboard for the depth hole filler: predicts filled pixels and compares the output stream
module dhf_fill_scoreboard (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    dhf_in_if                           i_pix,
    dhf_out_if                          i_res,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [dhf_pkg::PADDR_W-1:0] paddr,
    input  logic [dhf_pkg::PDATA_W-1:0] pwdata,
    input  logic                        pready,
    output int                          o_errors,
    output int                          o_outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    import dhf_pkg::*;

    localparam int unsigned RING_N     = 2 * MAX_WIDTH_DEF + 2;
    localparam int unsigned HEIGHT_TOP = 4096;
    localparam logic [PADDR_W-1:0] WIDTH_ADDR  = {REG_FRAME_WIDTH, 2'b00};
    localparam logic [PADDR_W-1:0] HEIGHT_ADDR = {REG_FRAME_HEIGHT, 2'b00};
    localparam int MAX_REPORTS = 100;

    typedef struct packed {
        logic [PIX_W-1:0] value;
        logic             last;
    } t_fill;

    logic [PIX_W-1:0] depth_ring [RING_N];
    int unsigned      width_reg;
    int unsigned      height_reg;
    int unsigned      in_col;
    int unsigned      in_row;
    int unsigned      out_col;
    int unsigned      out_row;
    t_fill            filled_q [$];
    int               err_cnt = 0;

    function automatic int unsigned cols();
        if (width_reg < 1) return 1;
        if (width_reg > MAX_WIDTH_DEF) return MAX_WIDTH_DEF;
        return width_reg;
    endfunction

    function automatic int unsigned rows();
        if (height_reg < 1) return 1;
        if (height_reg > HEIGHT_TOP) return HEIGHT_TOP;
        return height_reg;
    endfunction

    function automatic void restart_frame();
        in_col  = 0;
        in_row  = 0;
        out_col = 0;
        out_row = 0;
    endfunction

    // the live pixel is the incoming one, not yet written to the ring
    function automatic logic [PIX_W-1:0] ring_at(int unsigned pos, int unsigned live_pos,
                                                  logic [PIX_W-1:0] live_v, bit live);
        if (live && pos == live_pos) return live_v;
        return depth_ring[pos % RING_N];
    endfunction

    function automatic t_fill fill_next(int unsigned live_pos, logic [PIX_W-1:0] live_v,
                                        bit live);
        int unsigned      w;
        int unsigned      h;
        int unsigned      total;
        int unsigned      p;
        int unsigned      sum;
        int unsigned      cnt;
        int               x;
        int               y;
        logic [PIX_W-1:0] v;
        logic [PIX_W-1:0] nv;
        t_fill            r;
        w     = cols();
        h     = rows();
        total = w * h;
        p     = out_row * w + out_col;
        v     = ring_at(p, live_pos, live_v, live);
        if (v == '0) begin
            sum = 0;
            cnt = 0;
            for (int dy = -1; dy <= 1; dy++) begin
                for (int dx = -1; dx <= 1; dx++) begin
                    x = int'(out_col) + dx;
                    y = int'(out_row) + dy;
                    if ((dx != 0 || dy != 0) && x >= 0 && y >= 0 &&
                        x < int'(w) && y < int'(h)) begin
                        nv = ring_at(int'(y) * w + int'(x), live_pos, live_v, live);
                        if (nv != '0) begin
                            sum += nv;
                            cnt++;
                        end
                    end
                end
            end
            v = (cnt != 0) ? PIX_W'(sum / cnt) : '0;
        end
        depth_ring[p % RING_N] = v;
        r.value = v;
        r.last  = (p == total - 1);
        if (r.last) begin
            restart_frame();
        end else begin
            out_col++;
            if (out_col >= w) begin
                out_col = 0;
                out_row++;
            end
        end
        return r;
    endfunction

    function automatic void take_item(logic c, logic [PIX_W-1:0] v);
        int unsigned w;
        int unsigned total;
        int unsigned in_pos;
        int unsigned out_pos;
        int unsigned pend;
        w       = cols();
        total   = w * rows();
        in_pos  = in_row * w + in_col;
        out_pos = out_row * w + out_col;
        pend    = in_pos - out_pos;
        if (c == CMD_PIXEL && in_pos < total) begin
            if (pend == w + 1) filled_q.push_back(fill_next(in_pos, v, 1'b1));
            depth_ring[in_pos % RING_N] = v;
            in_col++;
            if (in_col >= w) begin
                in_col = 0;
                in_row++;
            end
        end else if (in_pos >= total && pend > 0) begin
            filled_q.push_back(fill_next(0, '0, 1'b0));
        end
    endfunction

    always @(posedge i_clk) begin
        t_fill exp_t;
        if (!i_rst_n) begin
            for (int i = 0; i < RING_N; i++) depth_ring[i] = '0;
            width_reg  = FW_RESET;
            height_reg = FH_RESET;
            restart_frame();
            filled_q.delete();
        end else begin
            if (i_res.valid && i_res.ready) begin
                if (filled_q.size() == 0) begin
                    err_cnt++;
                    if (err_cnt <= MAX_REPORTS)
                        $display("%0t: unexpected transaction filled_value=%0d frame_end=%0b",
                                 $time, i_res.filled_value, i_res.frame_end);
                end else begin
                    exp_t = filled_q.pop_front();
                    if (exp_t.value !== i_res.filled_value) begin
                        err_cnt++;
                        if (err_cnt <= MAX_REPORTS)
                            $display("%0t: filled_value expected %0d actual %0d",
                                     $time, exp_t.value, i_res.filled_value);
                    end
                    if (exp_t.last !== i_res.frame_end) begin
                        err_cnt++;
                        if (err_cnt <= MAX_REPORTS)
                            $display("%0t: frame_end expected %0b actual %0b",
                                     $time, exp_t.last, i_res.frame_end);
                    end
                end
            end
            if (psel && penable && pwrite && pready) begin
                if (paddr == WIDTH_ADDR) begin
                    width_reg = pwdata[FW_W-1:0];
                    restart_frame();
                end else if (paddr == HEIGHT_ADDR) begin
                    height_reg = pwdata[FH_W-1:0];
                    restart_frame();
                end
            end
            if (i_pix.valid && i_pix.ready) take_item(i_pix.cmd, i_pix.pixel_value);
        end
        o_outstanding <= filled_q.size();
        o_errors      <= err_cnt;
    end

endmodule

FILE: bench/testbench.sv
// top of the depth hole filler bench: clock, reset, stimulus, output stalls and verdict
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import dhf_pkg::*;

    localparam logic [PADDR_W-1:0] WIDTH_ADDR  = {REG_FRAME_WIDTH, 2'b00};
    localparam logic [PADDR_W-1:0] HEIGHT_ADDR = {REG_FRAME_HEIGHT, 2'b00};
    localparam int RANDOM_ITEMS = 420;
    localparam int SETTLE_CYCLES = 24;

    typedef enum int {SINK_OPEN, SINK_COIN, SINK_SLOW, SINK_PERIODIC} t_sink_mode;

    logic               i_clk;
    logic               i_rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic               pready;
    int                 errors;
    int                 outstanding;
    int                 items_sent;
    int                 burst_left;
    bit                 no_gaps;
    t_sink_mode         sink_mode;
    int                 sink_span;
    int                 sink_tick;

    dhf_in_if  pix_if ();
    dhf_out_if res_if ();

    depth_hole_fill_neighbor_mean_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pix   (pix_if),
        .o_res   (res_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    dhf_fill_scoreboard fill_sb (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_pix         (pix_if),
        .i_res         (res_if),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .pready        (pready),
        .o_errors      (errors),
        .o_outstanding (outstanding)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #10_000_000;
        $display("depth_hole_fill_neighbor_mean_top verification failed");
        $finish;
    end

    // output stalls
    initial begin
        res_if.ready = 1'b0;
        sink_tick = 0;
        forever begin
            sink_mode = t_sink_mode'($urandom_range(3));
            sink_span = $urandom_range(8, 150);
            repeat (sink_span) begin
                @(posedge i_clk);
                sink_tick++;
                case (sink_mode)
                    SINK_OPEN:     res_if.ready <= 1'b1;
                    SINK_COIN:     res_if.ready <= $urandom_range(1);
                    SINK_SLOW:     res_if.ready <= ($urandom_range(3) == 0);
                    SINK_PERIODIC: res_if.ready <= ((sink_tick % 5) < 3);
                    default:       res_if.ready <= 1'b1;
                endcase
            end
        end
    end

    task automatic reg_write(input logic [PADDR_W-1:0] addr, input logic [PDATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic configure(input int unsigned w_raw, input int unsigned h_raw);
        logic [PDATA_W-1:0] d;
        d = $urandom_range(1) ? PDATA_W'($urandom) : '0;
        d[FW_W-1:0] = w_raw[FW_W-1:0];
        reg_write(WIDTH_ADDR, d);
        d = $urandom_range(1) ? PDATA_W'($urandom) : '0;
        d[FH_W-1:0] = h_raw[FH_W-1:0];
        reg_write(HEIGHT_ADDR, d);
    endtask

    task automatic send_item(input logic c, input logic [PIX_W-1:0] v);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            if (no_gaps) gap = 0;
            else if ($urandom_range(7) == 0) gap = $urandom_range(8, 20);
            else gap = $urandom_range(0, 3);
            if (gap > 0) begin
                pix_if.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        pix_if.valid       <= 1'b1;
        pix_if.cmd         <= c;
        pix_if.pixel_value <= v;
        @(posedge i_clk);
        while (!pix_if.ready) @(posedge i_clk);
        items_sent++;
    endtask

    // wait for every filled pixel, then let the block finish its last transaction
    task automatic settle();
        pix_if.valid <= 1'b0;
        @(posedge i_clk);
        while (outstanding != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    function automatic logic [PIX_W-1:0] rand_pixel(int unsigned hole_pct);
        if ($urandom_range(99) < hole_pct) return '0;
        case ($urandom_range(7))
            0:       return 8'd255;
            1:       return 8'd1;
            default: return PIX_W'($urandom_range(1, 255));
        endcase
    endfunction

    function automatic int unsigned rand_hole_pct();
        case ($urandom_range(4))
            0:       return 0;
            1:       return 100;
            2:       return 90;
            default: return $urandom_range(10, 60);
        endcase
    endfunction

    // n_in below w*h leaves the frame unfinished
    task automatic run_frame(input int unsigned w, input int unsigned h,
                             input int unsigned hole_pct, input int unsigned n_in);
        int unsigned total;
        int unsigned flush;
        total = w * h;
        for (int unsigned i = 0; i < n_in; i++) begin
            if ($urandom_range(24) == 0) send_item(CMD_DRAIN, PIX_W'($urandom));
            send_item(CMD_PIXEL, rand_pixel(hole_pct));
        end
        if (n_in == total) begin
            flush = (total < w + 1) ? total : w + 1;
            for (int unsigned i = 0; i < flush; i++) begin
                if ($urandom_range(4) == 0) send_item(CMD_PIXEL, PIX_W'($urandom));
                else send_item(CMD_DRAIN, PIX_W'($urandom));
            end
            if ($urandom_range(3) == 0) send_item(CMD_DRAIN, PIX_W'($urandom));
        end
    endtask

    initial begin
        logic [PIX_W-1:0] grid [9];
        int unsigned      w_raw;
        int unsigned      h_raw;
        int unsigned      w;
        int unsigned      h;
        int unsigned      total;
        int unsigned      n_in;
        int               base;
        int               frames;

        i_rst_n            = 1'b0;
        psel               = 1'b0;
        penable            = 1'b0;
        pwrite             = 1'b0;
        paddr              = '0;
        pwdata             = '0;
        pix_if.valid       = 1'b0;
        pix_if.cmd         = CMD_PIXEL;
        pix_if.pixel_value = '0;
        burst_left         = 0;
        no_gaps            = 1'b0;
        items_sent         = 0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // 3x2 frame of holes only, early drain and a pixel during the flush
        configure(3, 2);
        send_item(CMD_DRAIN, 8'hA5);
        repeat (6) send_item(CMD_PIXEL, 8'd0);
        repeat (3) send_item(CMD_DRAIN, 8'h5A);
        send_item(CMD_PIXEL, 8'd77);
        send_item(CMD_DRAIN, 8'hFF);
        settle();

        // 3x3 frame mixing extremes and holes
        configure(3, 3);
        grid = '{8'd255, 8'd0, 8'd255, 8'd0, 8'd1, 8'd0, 8'd255, 8'd0, 8'd128};
        for (int i = 0; i < 9; i++) send_item(CMD_PIXEL, grid[i]);
        send_item(CMD_DRAIN, 8'd0);
        send_item(CMD_PIXEL, 8'd200);
        send_item(CMD_DRAIN, 8'd0);
        send_item(CMD_DRAIN, 8'd0);
        settle();

        // clamped extremes: widest frame cut short, tallest frame cut short, 1x1 frame
        configure(1023, 3);
        run_frame(512, 3, 30, 600);
        settle();
        configure(0, 8191);
        run_frame(1, 4096, 40, 40);
        settle();
        configure(0, 0);
        run_frame(1, 1, 50, 1);
        run_frame(1, 1, 100, 1);
        settle();

        base = items_sent;
        while (items_sent - base < RANDOM_ITEMS) begin
            case ($urandom_range(9))
                0:       w_raw = 0;
                1:       w_raw = 1;
                default: w_raw = $urandom_range(2, 12);
            endcase
            case ($urandom_range(9))
                0:       h_raw = 0;
                1:       h_raw = 1;
                default: h_raw = $urandom_range(2, 8);
            endcase
            w = (w_raw < 1) ? 1 : w_raw;
            h = (h_raw < 1) ? 1 : h_raw;
            total = w * h;
            configure(w_raw, h_raw);
            frames = $urandom_range(1, 3);
            for (int f = 0; f < frames; f++) begin
                no_gaps = ($urandom_range(3) == 0);
                if (total > 1 && $urandom_range(7) == 0) n_in = $urandom_range(1, total - 1);
                else n_in = total;
                run_frame(w, h, rand_hole_pct(), n_in);
                if (n_in < total) break;
            end
            settle();
        end

        settle();
        if (errors == 0 && outstanding == 0) begin
            $display("depth_hole_fill_neighbor_mean_top verification clean");
        end else begin
            $display("depth_hole_fill_neighbor_mean_top verification failed");
        end
        $finish;
    end

endmodule

FILE: filelist.f
src/dhf_pkg.sv
src/dhf_if.sv
src/dhf_ctrl.sv
src/dhf_datapath.sv
src/depth_hole_fill_neighbor_mean_top.sv
bench/dhf_fill_scoreboard.sv
bench/testbench.sv
